// File: rtl/chlsi_pkg.sv
// Shared types, register codes and saturating fixed-point helpers.
`timescale 1ns / 1ps
`default_nettype none

package chlsi_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int EVAL_STAGES = 7;
	localparam logic signed [31:0] RIGHT_X_RST = 32'sd65536;

	typedef enum logic [2:0] {
		REG_LEFT_X      = 3'd0,
		REG_LEFT_VALUE  = 3'd1,
		REG_LEFT_SLOPE  = 3'd2,
		REG_RIGHT_X     = 3'd3,
		REG_RIGHT_VALUE = 3'd4,
		REG_RIGHT_SLOPE = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] left_x;
		logic signed [31:0] left_value;
		logic signed [31:0] left_slope;
		logic signed [31:0] right_x;
		logic signed [31:0] right_value;
		logic signed [31:0] right_slope;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] xbar;
		logic signed [31:0] c0;
		logic signed [31:0] c1;
		logic signed [31:0] c2;
		logic signed [31:0] c3;
		logic signed [31:0] xm;
		logic signed [31:0] xp;
		logic               h_zero;
		logic               min_none;
	} coef_t;

	typedef enum logic [3:0] {
		S_IDLE, S_BASE, S_MGH, S_MSH, S_C0,
		S_DV1, S_DV2, S_DV3, S_DV4, S_DV5,
		S_AB, S_DV6, S_DV7, S_PP, S_DISC, S_SQ
	} setup_state_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return sat32(64'(a) + 64'(b));
	endfunction

	function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return sat32(64'(a) - 64'(b));
	endfunction

	// product rounded to nearest, ties up
	function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
			input logic signed [31:0] b, input int frac);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return sat32((p + (64'sd1 <<< (frac - 1))) >>> frac);
	endfunction

	// small constant times 2^-sh, same rounding
	function automatic logic signed [31:0] qscl(input logic signed [31:0] a,
			input int num, input int sh);
		logic signed [63:0] p;
		p = 64'(a) * 64'(num);
		if (sh > 0)
			p = p + (64'sd1 <<< (sh - 1));
		return sat32(p >>> sh);
	endfunction

endpackage

`default_nettype wire

// File: rtl/cubic_hermite_line_search_interpolant.sv
// Top level: register file, coefficient sequencer, two evaluation lanes, result select.
`timescale 1ns / 1ps
`default_nettype none

// Cubic Hermite interpolant over a line-search interval, Q(32-FRAC_BITS).FRAC_BITS.
// Config: cfg_we/cfg_index/cfg_data write the six end-point registers
// (left_x, left_value, left_slope, right_x, right_value, right_slope).
// Every write to one of the six registers, and reset, starts the coefficient
// sequencer: it raises busy while it runs seven passes through one bit-serial
// divider and a bit-serial square root; it ends sooner when the cubic term is
// zero or disc is negative.
// Requests: a request is taken on a clock edge with start high and busy low.
// mode 0 evaluates the cubic at query_x; mode 1 returns the lower extremum.
// Throughput: one request per cycle while busy is low.
// done pulses for one cycle once the request has passed the evaluation pipeline
// and the output register, carrying point_x, value, slope, curvature and no_result.
// Results are never held back; the receiver must take each done cycle.
// Reset clears the registers to their defaults (right_x = 1.0) and drops
// all requests in flight.
module cubic_hermite_line_search_interpolant #(
	parameter int FRAC_BITS = chlsi_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               mode,
	input  wire logic signed [31:0] query_x,
	output logic                    done,
	output logic signed [31:0]      point_x,
	output logic signed [31:0]      value,
	output logic signed [31:0]      slope,
	output logic signed [31:0]      curvature,
	output logic                    no_result,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	localparam int ES = chlsi_pkg::EVAL_STAGES;

	chlsi_pkg::cfg_t  cfg_q;
	chlsi_pkg::coef_t coef;

	logic               accept;
	logic               kick;
	logic [ES-1:0]      vld_q;
	logic [ES-1:0]      mode_q;
	logic signed [31:0] xa;
	logic signed [31:0] pa, fa, ga, ka;
	logic signed [31:0] pb, fb, gb, kb;
	logic               m_last;

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_x <= '0;
			cfg_q.left_value <= '0;
			cfg_q.left_slope <= '0;
			cfg_q.right_x <= chlsi_pkg::RIGHT_X_RST;
			cfg_q.right_value <= '0;
			cfg_q.right_slope <= '0;
		end else if (cfg_we) begin
			unique case (chlsi_pkg::reg_idx_t'(cfg_index))
				chlsi_pkg::REG_LEFT_X:      cfg_q.left_x <= cfg_data;
				chlsi_pkg::REG_LEFT_VALUE:  cfg_q.left_value <= cfg_data;
				chlsi_pkg::REG_LEFT_SLOPE:  cfg_q.left_slope <= cfg_data;
				chlsi_pkg::REG_RIGHT_X:     cfg_q.right_x <= cfg_data;
				chlsi_pkg::REG_RIGHT_VALUE: cfg_q.right_value <= cfg_data;
				chlsi_pkg::REG_RIGHT_SLOPE: cfg_q.right_slope <= cfg_data;
				default: ;
			endcase
		end
	end

	// writes beyond the register list change nothing, so no rerun
	assign kick = cfg_we && (cfg_index <= 3'(chlsi_pkg::REG_RIGHT_SLOPE));

	chlsi_setup #(.FRAC_BITS(FRAC_BITS)) u_setup (
		.clk(clk), .arst_n(arst_n), .kick(kick), .cfg(cfg_q),
		.busy(busy), .coef(coef)
	);

	// lane A: query or first extremum candidate; lane B: second candidate
	assign xa = mode ? coef.xm : query_x;

	chlsi_eval #(.FRAC_BITS(FRAC_BITS)) u_eval_a (
		.clk(clk), .coef(coef), .x(xa),
		.point(pa), .fval(fa), .gval(ga), .kval(ka)
	);

	chlsi_eval #(.FRAC_BITS(FRAC_BITS)) u_eval_b (
		.clk(clk), .coef(coef), .x(coef.xp),
		.point(pb), .fval(fb), .gval(gb), .kval(kb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= {vld_q[ES-2:0], accept};
	end

	always_ff @(posedge clk)
		mode_q <= {mode_q[ES-2:0], mode};

	assign m_last = mode_q[ES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= vld_q[ES-1];
	end

	always_ff @(posedge clk) begin
		if (coef.h_zero) begin
			point_x <= m_last ? 32'sd0 : pa;
			value <= '0;
			slope <= '0;
			curvature <= '0;
			no_result <= 1'b1;
		end else if (m_last && coef.min_none) begin
			point_x <= '0;
			value <= '0;
			slope <= '0;
			curvature <= '0;
			no_result <= 1'b1;
		end else if (m_last && !(fa < fb)) begin
			point_x <= pb;
			value <= fb;
			slope <= gb;
			curvature <= kb;
			no_result <= 1'b0;
		end else begin
			point_x <= pa;
			value <= fa;
			slope <= ga;
			curvature <= ka;
			no_result <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// File: rtl/chlsi_div.sv
// Iterative signed fixed-point divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module chlsi_div #(
	parameter int FRAC_BITS = chlsi_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [31:0] n,
	input  wire logic signed [31:0] d,
	output logic                    done,
	output logic signed [31:0]      q
);

	localparam int NW = 33 + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [31:0]   rem_q;
	logic [31:0]   ud_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          neg_q;
	logic          dz_q;
	logic          npos_q;
	logic          nneg_q;
	logic [31:0]   un;
	logic [31:0]   ud;
	logic [32:0]   trial;
	logic          ge;
	logic          big;

	assign un = n[31] ? (~n + 32'd1) : n;
	assign ud = d[31] ? (~d + 32'd1) : d;
	assign trial = {rem_q, num_q[NW-1]};
	assign ge = trial >= {1'b0, ud_q};
	assign big = |num_q[NW-1:31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				if (cnt_q != '0)
					cnt_q <= cnt_q - CW'(1);
				else begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= (NW'(un) << FRAC_BITS) + NW'(ud >> 1);
			rem_q <= '0;
			ud_q <= ud;
			neg_q <= n[31] != d[31];
			dz_q <= d == 32'sd0;
			npos_q <= n > 32'sd0;
			nneg_q <= n[31];
		end else if (run_q) begin
			if (cnt_q != '0) begin
				rem_q <= ge ? 32'(trial - {1'b0, ud_q}) : trial[31:0];
				num_q <= {num_q[NW-2:0], ge};
			end else if (dz_q)
				q <= npos_q ? 32'sh7fffffff : (nneg_q ? 32'sh80000000 : 32'sd0);
			else if (big)
				q <= neg_q ? 32'sh80000000 : 32'sh7fffffff;
			else
				q <= neg_q ? -$signed({1'b0, num_q[30:0]}) : $signed({1'b0, num_q[30:0]});
		end
	end

endmodule

`default_nettype wire

// File: rtl/chlsi_sqrt.sv
// Iterative integer square root of disc << FRAC_BITS, one root bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module chlsi_sqrt #(
	parameter int FRAC_BITS = chlsi_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [31:0] v,
	output logic                    done,
	output logic signed [31:0]      r
);

	localparam int RW = 32 + FRAC_BITS;
	localparam int RW2 = RW + (RW % 2);
	localparam int HW = RW2 / 2;
	localparam int CW = $clog2(HW + 1);

	logic [RW2-1:0] rad_q;
	logic [HW-1:0]  root_q;
	logic [HW+1:0]  rem_q;
	logic [CW-1:0]  cnt_q;
	logic           run_q;
	logic [HW+3:0]  trem;
	logic [HW+3:0]  trial;
	logic           ge;

	assign trem = {rem_q, rad_q[RW2-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge = trem >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(HW);
			end else if (run_q) begin
				if (cnt_q != '0)
					cnt_q <= cnt_q - CW'(1);
				else begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= RW2'(v[30:0]) << FRAC_BITS;
			root_q <= '0;
			rem_q <= '0;
		end else if (run_q) begin
			if (cnt_q != '0) begin
				rem_q <= ge ? (HW+2)'(trem - trial) : trem[HW+1:0];
				root_q <= {root_q[HW-2:0], ge};
				rad_q <= rad_q << 2;
			end else
				r <= 32'(root_q);
		end
	end

endmodule

`default_nettype wire

// File: rtl/chlsi_setup.sv
// Coefficient and extremum sequencer, rerun after reset and each register write.
`timescale 1ns / 1ps
`default_nettype none

module chlsi_setup #(
	parameter int FRAC_BITS = chlsi_pkg::FRAC_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           kick,
	input  wire chlsi_pkg::cfg_t cfg,
	output logic                busy,
	output chlsi_pkg::coef_t    coef
);

	chlsi_pkg::setup_state_t state_q, state_d;

	logic signed [31:0] h_q, xbar_q, sv_q, dv_q, sg_q, dg_q;
	logic signed [31:0] mgh_q, msh_q, tmp_q;
	logic signed [31:0] c0_q, c1_q, c2_q, c3_q;
	logic signed [31:0] a_q, p_q, ca_q, pp_q, xm_q, xp_q;
	logic               hz_q, none_q;

	logic               div_start, div_done;
	logic signed [31:0] div_n, div_d, div_q;
	logic               sq_start, sq_done;
	logic signed [31:0] sq_r;
	logic signed [31:0] a_c, b_c, disc_c;

	chlsi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.n(div_n), .d(div_d), .done(div_done), .q(div_q)
	);

	chlsi_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start),
		.v(disc_c), .done(sq_done), .r(sq_r)
	);

	assign a_c = chlsi_pkg::qscl(c3_q, 3, 0);
	assign b_c = chlsi_pkg::qscl(c2_q, 2, 0);
	assign disc_c = chlsi_pkg::qsub(pp_q, ca_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= chlsi_pkg::S_BASE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		div_n = dv_q;
		div_d = h_q;
		sq_start = 1'b0;
		unique case (state_q)
			chlsi_pkg::S_IDLE: ;
			chlsi_pkg::S_BASE: state_d = chlsi_pkg::S_MGH;
			chlsi_pkg::S_MGH:  state_d = chlsi_pkg::S_MSH;
			chlsi_pkg::S_MSH:  state_d = chlsi_pkg::S_C0;
			chlsi_pkg::S_C0: begin
				div_start = 1'b1;
				state_d = chlsi_pkg::S_DV1;
			end
			chlsi_pkg::S_DV1: if (div_done) begin
				div_start = 1'b1;
				div_n = dg_q;
				state_d = chlsi_pkg::S_DV2;
			end
			chlsi_pkg::S_DV2: if (div_done) begin
				div_start = 1'b1;
				div_n = tmp_q;
				state_d = chlsi_pkg::S_DV3;
			end
			chlsi_pkg::S_DV3: if (div_done) begin
				div_start = 1'b1;
				div_n = div_q;
				state_d = chlsi_pkg::S_DV4;
			end
			chlsi_pkg::S_DV4: if (div_done) begin
				div_start = 1'b1;
				div_n = div_q;
				state_d = chlsi_pkg::S_DV5;
			end
			chlsi_pkg::S_DV5: if (div_done) state_d = chlsi_pkg::S_AB;
			chlsi_pkg::S_AB: begin
				if (a_c == 32'sd0)
					state_d = chlsi_pkg::S_IDLE;
				else begin
					div_start = 1'b1;
					div_n = b_c;
					div_d = chlsi_pkg::qscl(a_c, 2, 0);
					state_d = chlsi_pkg::S_DV6;
				end
			end
			chlsi_pkg::S_DV6: if (div_done) begin
				div_start = 1'b1;
				div_n = c1_q;
				div_d = a_q;
				state_d = chlsi_pkg::S_DV7;
			end
			chlsi_pkg::S_DV7: if (div_done) state_d = chlsi_pkg::S_PP;
			chlsi_pkg::S_PP:  state_d = chlsi_pkg::S_DISC;
			chlsi_pkg::S_DISC: begin
				if (disc_c < 32'sd0)
					state_d = chlsi_pkg::S_IDLE;
				else begin
					sq_start = 1'b1;
					state_d = chlsi_pkg::S_SQ;
				end
			end
			chlsi_pkg::S_SQ: if (sq_done) state_d = chlsi_pkg::S_IDLE;
			default: state_d = chlsi_pkg::S_IDLE;
		endcase
		if (kick)
			state_d = chlsi_pkg::S_BASE;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			chlsi_pkg::S_BASE: begin
				h_q <= chlsi_pkg::sat32(64'(cfg.right_x) - 64'(cfg.left_x));
				xbar_q <= 32'((64'(cfg.left_x) + 64'(cfg.right_x)) >>> 1);
				sv_q <= chlsi_pkg::qadd(cfg.right_value, cfg.left_value);
				dv_q <= chlsi_pkg::qsub(cfg.right_value, cfg.left_value);
				sg_q <= chlsi_pkg::qadd(cfg.right_slope, cfg.left_slope);
				dg_q <= chlsi_pkg::qsub(cfg.right_slope, cfg.left_slope);
				hz_q <= cfg.right_x == cfg.left_x;
				none_q <= 1'b0;
			end
			chlsi_pkg::S_MGH: mgh_q <= chlsi_pkg::qmul(dg_q, h_q, FRAC_BITS);
			chlsi_pkg::S_MSH: msh_q <= chlsi_pkg::qmul(sg_q, h_q, FRAC_BITS);
			chlsi_pkg::S_C0: begin
				c0_q <= chlsi_pkg::qsub(chlsi_pkg::qscl(sv_q, 1, 1),
					chlsi_pkg::qscl(mgh_q, 1, 3));
				tmp_q <= chlsi_pkg::qadd(chlsi_pkg::qscl(dv_q, -2, 0), msh_q);
			end
			chlsi_pkg::S_DV1: if (div_done)
				c1_q <= chlsi_pkg::qsub(chlsi_pkg::qscl(div_q, 3, 1),
					chlsi_pkg::qscl(sg_q, 1, 2));
			chlsi_pkg::S_DV2: if (div_done) c2_q <= chlsi_pkg::qscl(div_q, 1, 1);
			chlsi_pkg::S_DV5: if (div_done) c3_q <= div_q;
			chlsi_pkg::S_AB: begin
				a_q <= a_c;
				if (a_c == 32'sd0)
					none_q <= 1'b1;
			end
			chlsi_pkg::S_DV6: if (div_done) p_q <= div_q;
			chlsi_pkg::S_DV7: if (div_done) ca_q <= div_q;
			chlsi_pkg::S_PP: pp_q <= chlsi_pkg::qmul(p_q, p_q, FRAC_BITS);
			chlsi_pkg::S_DISC: if (disc_c < 32'sd0) none_q <= 1'b1;
			chlsi_pkg::S_SQ: if (sq_done) begin
				xm_q <= chlsi_pkg::qadd(chlsi_pkg::qsub(xbar_q, p_q), sq_r);
				xp_q <= chlsi_pkg::qsub(chlsi_pkg::qsub(xbar_q, p_q), sq_r);
			end
			default: ;
		endcase
	end

	assign busy = state_q != chlsi_pkg::S_IDLE;

	always_comb begin
		coef.xbar = xbar_q;
		coef.c0 = c0_q;
		coef.c1 = c1_q;
		coef.c2 = c2_q;
		coef.c3 = c3_q;
		coef.xm = xm_q;
		coef.xp = xp_q;
		coef.h_zero = hz_q;
		coef.min_none = none_q;
	end

endmodule

`default_nettype wire

// File: rtl/chlsi_eval.sv
// Seven-stage cubic evaluation lane: value, slope and curvature at one point.
`timescale 1ns / 1ps
`default_nettype none

module chlsi_eval #(
	parameter int FRAC_BITS = chlsi_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire chlsi_pkg::coef_t   coef,
	input  wire logic signed [31:0] x,
	output logic signed [31:0]      point,
	output logic signed [31:0]      fval,
	output logic signed [31:0]      gval,
	output logic signed [31:0]      kval
);

	logic signed [31:0] two_c2;
	logic signed [31:0] x_s1, t_s1;
	logic signed [31:0] x_s2, t_s2, tc3_s2;
	logic signed [31:0] x_s3, t_s3, u_s3, w_s3, k_s3;
	logic signed [31:0] x_s4, t_s4, k_s4, tu_s4, tw_s4;
	logic signed [31:0] x_s5, t_s5, k_s5, v_s5, g_s5;
	logic signed [31:0] x_s6, k_s6, g_s6, tv_s6;
	logic signed [31:0] x_s7, k_s7, g_s7, f_s7;

	assign two_c2 = chlsi_pkg::qscl(coef.c2, 2, 0);

	always_ff @(posedge clk) begin
		x_s1 <= x;
		t_s1 <= chlsi_pkg::qsub(x, coef.xbar);

		x_s2 <= x_s1;
		t_s2 <= t_s1;
		tc3_s2 <= chlsi_pkg::qmul(t_s1, coef.c3, FRAC_BITS);

		x_s3 <= x_s2;
		t_s3 <= t_s2;
		u_s3 <= chlsi_pkg::qadd(coef.c2, tc3_s2);
		w_s3 <= chlsi_pkg::qadd(two_c2, chlsi_pkg::qscl(tc3_s2, 3, 0));
		k_s3 <= chlsi_pkg::qadd(two_c2, chlsi_pkg::qscl(tc3_s2, 6, 0));

		x_s4 <= x_s3;
		t_s4 <= t_s3;
		k_s4 <= k_s3;
		tu_s4 <= chlsi_pkg::qmul(t_s3, u_s3, FRAC_BITS);
		tw_s4 <= chlsi_pkg::qmul(t_s3, w_s3, FRAC_BITS);

		x_s5 <= x_s4;
		t_s5 <= t_s4;
		k_s5 <= k_s4;
		v_s5 <= chlsi_pkg::qadd(coef.c1, tu_s4);
		g_s5 <= chlsi_pkg::qadd(coef.c1, tw_s4);

		x_s6 <= x_s5;
		k_s6 <= k_s5;
		g_s6 <= g_s5;
		tv_s6 <= chlsi_pkg::qmul(t_s5, v_s5, FRAC_BITS);

		x_s7 <= x_s6;
		k_s7 <= k_s6;
		g_s7 <= g_s6;
		f_s7 <= chlsi_pkg::qadd(coef.c0, tv_s6);
	end

	assign point = x_s7;
	assign fval = f_s7;
	assign gval = g_s7;
	assign kval = k_s7;

endmodule

`default_nettype wire

// File: tb/cubic_hermite_line_search_interpolant_test.sv
// Self-checking testbench for the cubic Hermite line-search interpolant.
`timescale 1ns / 1ps

module cubic_hermite_line_search_interpolant_test;

	localparam int FRAC = chlsi_pkg::FRAC_BITS_DEF;
	localparam int DRAIN_CYCLES = 16;
	localparam int STALL_LIMIT = 50000;
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam logic MODE_EVAL = 1'b0;
	localparam logic MODE_MIN = 1'b1;
	localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;
	localparam logic signed [31:0] Q_ONE = 32'sh00010000;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] value;
		logic signed [31:0] slope;
		logic signed [31:0] curvature;
		logic               no_result;
	} interp_t;

	typedef enum logic { ROW_CFG, ROW_REQ } row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [2:0]        idx;
		logic [31:0]       data;
		logic              md;
		logic signed [31:0] qx;
		bit                typed;
		interp_t           exp;
	} row_t;

	logic clk, arst_n, start, busy, mode, done, no_result, cfg_we;
	logic signed [31:0] query_x, point_x, value, slope, curvature;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	logic signed [31:0] end_regs [6];
	interp_t pending [$];
	int errors = 0;
	int stall_cnt = 0;
	int idle_pct = 0;

	cubic_hermite_line_search_interpolant uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.query_x(query_x), .done(done), .point_x(point_x), .value(value),
		.slope(slope), .curvature(curvature), .no_result(no_result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------- fixed-point predictor ----------------
	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// floor((v + half) / 2^sh): nearest, ties up
	function automatic longint round_shift(longint v, int sh);
		if (sh <= 0) return v;
		return (v + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		return clamp32(round_shift(a * b, FRAC));
	endfunction

	function automatic longint fx_scale(longint a, longint num, int sh);
		return clamp32(round_shift(a * num, sh));
	endfunction

	function automatic longint fx_div(longint n, longint d);
		longint unsigned un, ud, q;
		bit neg;
		if (d == 0) return n > 0 ? 64'sd2147483647 : (n < 0 ? -64'sd2147483648 : 0);
		un = n < 0 ? -n : n;
		ud = d < 0 ? -d : d;
		q = ((un << FRAC) + ud / 2) / ud;
		if (q > 64'd4294967296) q = 64'd4294967296;
		neg = (n < 0) != (d < 0);
		return clamp32(neg ? -longint'(q) : longint'(q));
	endfunction

	function automatic longint floor_sqrt(longint unsigned v);
		longint unsigned r, t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v) r = t;
		end
		return longint'(r);
	endfunction

	function automatic void cubic_at(input longint c0, c1, c2, c3, t,
			output longint f, f1, f2);
		longint tc3, c2x2;
		tc3 = fx_mul(t, c3);
		c2x2 = fx_scale(c2, 2, 0);
		f = clamp32(c0 + fx_mul(t, clamp32(c1 + fx_mul(t, clamp32(c2 + tc3)))));
		f1 = clamp32(c1 + fx_mul(t, clamp32(c2x2 + fx_scale(tc3, 3, 0))));
		f2 = clamp32(c2x2 + fx_scale(tc3, 6, 0));
	endfunction

	function automatic interp_t predict_interp(logic md, logic signed [31:0] qx);
		longint x0, lv, ls, x1, rv, rs, h, mid, sv, dv, sg, dg, c0, c1, c2, c3;
		longint a, b, p, disc, r, xa, xb, fa, ga, ka, fb, gb, kb;
		interp_t res;
		x0 = end_regs[chlsi_pkg::REG_LEFT_X];
		lv = end_regs[chlsi_pkg::REG_LEFT_VALUE];
		ls = end_regs[chlsi_pkg::REG_LEFT_SLOPE];
		x1 = end_regs[chlsi_pkg::REG_RIGHT_X];
		rv = end_regs[chlsi_pkg::REG_RIGHT_VALUE];
		rs = end_regs[chlsi_pkg::REG_RIGHT_SLOPE];
		res = '0;
		h = clamp32(x1 - x0);
		mid = (x0 + x1) >>> 1;
		if (h == 0) begin
			res.point_x = md == MODE_EVAL ? qx : 32'sd0;
			res.no_result = 1'b1;
			return res;
		end
		sv = clamp32(rv + lv); dv = clamp32(rv - lv);
		sg = clamp32(rs + ls); dg = clamp32(rs - ls);
		c0 = clamp32(fx_scale(sv, 1, 1) - fx_scale(fx_mul(dg, h), 1, 3));
		c1 = clamp32(fx_scale(fx_div(dv, h), 3, 1) - fx_scale(sg, 1, 2));
		c2 = fx_scale(fx_div(dg, h), 1, 1);
		c3 = fx_div(fx_div(fx_div(clamp32(fx_scale(dv, -2, 0) + fx_mul(sg, h)), h), h), h);
		if (md == MODE_EVAL) begin
			res.point_x = qx;
			cubic_at(c0, c1, c2, c3, clamp32(longint'(qx) - mid), fa, ga, ka);
			res.value = 32'(fa); res.slope = 32'(ga); res.curvature = 32'(ka);
			return res;
		end
		a = fx_scale(c3, 3, 0);
		b = fx_scale(c2, 2, 0);
		if (a == 0) begin
			res.no_result = 1'b1;
			return res;
		end
		p = fx_div(b, fx_scale(a, 2, 0));
		disc = clamp32(fx_mul(p, p) - fx_div(c1, a));
		if (disc < 0) begin
			res.no_result = 1'b1;
			return res;
		end
		r = floor_sqrt(longint'(disc) << FRAC);
		xa = clamp32(clamp32(mid - p) + r);
		xb = clamp32(clamp32(mid - p) - r);
		cubic_at(c0, c1, c2, c3, clamp32(xa - mid), fa, ga, ka);
		cubic_at(c0, c1, c2, c3, clamp32(xb - mid), fb, gb, kb);
		if (fa < fb) begin
			res.point_x = 32'(xa); res.value = 32'(fa);
			res.slope = 32'(ga); res.curvature = 32'(ka);
		end else begin
			res.point_x = 32'(xb); res.value = 32'(fb);
			res.slope = 32'(gb); res.curvature = 32'(kb);
		end
		return res;
	endfunction

	// ---------------- checking ----------------
	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
	endtask

	always @(posedge clk) begin
		interp_t e;
		if (arst_n && ((start && !busy) || done || cfg_we))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("cubic_hermite_line_search_interpolant_test: errors");
			$finish;
		end
		if (arst_n && done) begin
			if (pending.size() == 0) begin
				report_mismatch("unexpected result", point_x, 32'h0);
			end else begin
				e = pending.pop_front();
				if (point_x !== e.point_x) report_mismatch("point_x", point_x, e.point_x);
				if (value !== e.value) report_mismatch("value", value, e.value);
				if (slope !== e.slope) report_mismatch("slope", slope, e.slope);
				if (curvature !== e.curvature)
					report_mismatch("curvature", curvature, e.curvature);
				if (no_result !== e.no_result)
					report_mismatch("no_result", 32'(no_result), 32'(e.no_result));
			end
		end
	end

	// ---------------- stimulus ----------------
	task automatic wait_drained();
		while (pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx < 3'd6) end_regs[idx] = data;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// start stays high across back-to-back requests; dropped for a random gap, before register writes and at the end
	task automatic issue_request(logic md, logic signed [31:0] qx, bit typed, interp_t exp);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		mode <= md;
		query_x <= qx;
		do @(posedge clk); while (busy);
		pending.push_back(typed ? exp : predict_interp(md, qx));
	endtask

	function automatic row_t cfg_row(logic [2:0] idx, logic [31:0] data);
		row_t r;
		r = '{ROW_CFG, idx, data, MODE_EVAL, 32'sd0, 1'b0, interp_t'('0)};
		return r;
	endfunction

	function automatic row_t req_row(logic md, logic signed [31:0] qx, bit typed,
			logic signed [31:0] px, logic nr);
		row_t r;
		r = '{ROW_REQ, 3'd0, 32'd0, md, qx, typed, interp_t'('0)};
		r.exp.point_x = px;
		r.exp.no_result = nr;
		return r;
	endfunction

	function automatic logic signed [31:0] rand_span(int unsigned lim);
		return $signed($urandom_range(2 * lim)) - $signed(lim);
	endfunction

	task automatic random_setting();
		int kind;
		logic signed [31:0] x0, hh;
		kind = $urandom_range(0, 9);
		if (kind < 6) begin
			// well-formed interval with moderate values: reaches the extremum path
			x0 = rand_span(32'h40000);
			hh = $urandom_range(32'h4000, 32'h40000);
			if ($urandom_range(1)) hh = -hh;
			write_reg(chlsi_pkg::REG_LEFT_X, x0);
			write_reg(chlsi_pkg::REG_RIGHT_X, x0 + hh);
			write_reg(chlsi_pkg::REG_LEFT_VALUE, rand_span(32'h40000));
			write_reg(chlsi_pkg::REG_RIGHT_VALUE, rand_span(32'h40000));
			write_reg(chlsi_pkg::REG_LEFT_SLOPE, rand_span(32'h40000));
			write_reg(chlsi_pkg::REG_RIGHT_SLOPE, rand_span(32'h40000));
		end else if (kind < 8) begin
			for (int i = 0; i < 6; i++) begin
				case ($urandom_range(3))
					0: write_reg(i[2:0], Q_MAX);
					1: write_reg(i[2:0], Q_MIN);
					default: write_reg(i[2:0], $urandom);
				endcase
			end
		end else if (kind == 8) begin
			write_reg(chlsi_pkg::REG_RIGHT_X, end_regs[chlsi_pkg::REG_LEFT_X]);
			write_reg(chlsi_pkg::REG_LEFT_SLOPE, $urandom);
		end else begin
			write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
			write_reg(chlsi_pkg::REG_RIGHT_VALUE, $urandom);
		end
	endtask

	initial begin
		row_t table_rows [$];
		row_t r;
		logic signed [31:0] lo, span, q;
		arst_n = 1'b0;
		start = 1'b0;
		mode = 1'b0;
		query_x = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int i = 0; i < 6; i++) end_regs[i] = 32'sd0;
		end_regs[chlsi_pkg::REG_RIGHT_X] = chlsi_pkg::RIGHT_X_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset state: flat zero cubic; mode 1 has no cubic term
		table_rows.push_back(req_row(MODE_EVAL, 32'sd0, 1, 32'sd0, 1'b0));
		table_rows.push_back(req_row(MODE_EVAL, Q_MAX, 1, Q_MAX, 1'b0));
		table_rows.push_back(req_row(MODE_EVAL, Q_MIN, 1, Q_MIN, 1'b0));
		table_rows.push_back(req_row(MODE_MIN, 32'sh5a5a5a5a, 1, 32'sd0, 1'b1));
		// coinciding ends
		table_rows.push_back(cfg_row(chlsi_pkg::REG_RIGHT_X, 32'h0));
		table_rows.push_back(req_row(MODE_EVAL, 32'sh12345, 1, 32'sh12345, 1'b1));
		table_rows.push_back(req_row(MODE_MIN, 32'sd0, 1, 32'sd0, 1'b1));
		// spare register indexes do nothing
		table_rows.push_back(cfg_row(REG_SPARE_LO, 32'hffffffff));
		table_rows.push_back(cfg_row(REG_SPARE_HI, 32'hffffffff));
		table_rows.push_back(req_row(MODE_EVAL, Q_MIN, 1, Q_MIN, 1'b1));
		// ordinary interval with a real minimum
		table_rows.push_back(cfg_row(chlsi_pkg::REG_RIGHT_X, 32'h20000));
		table_rows.push_back(cfg_row(chlsi_pkg::REG_LEFT_VALUE, Q_ONE));
		table_rows.push_back(cfg_row(chlsi_pkg::REG_RIGHT_VALUE, Q_ONE));
		table_rows.push_back(cfg_row(chlsi_pkg::REG_LEFT_SLOPE, 32'hfffe0000));
		table_rows.push_back(cfg_row(chlsi_pkg::REG_RIGHT_SLOPE, Q_ONE));
		table_rows.push_back(req_row(MODE_EVAL, 32'sh8000, 0, 0, 0));
		table_rows.push_back(req_row(MODE_MIN, 32'sd0, 0, 0, 0));
		// saturating extremes
		table_rows.push_back(cfg_row(chlsi_pkg::REG_LEFT_X, Q_MIN));
		table_rows.push_back(cfg_row(chlsi_pkg::REG_RIGHT_X, Q_MAX));
		table_rows.push_back(cfg_row(chlsi_pkg::REG_RIGHT_VALUE, Q_MAX));
		table_rows.push_back(cfg_row(chlsi_pkg::REG_RIGHT_SLOPE, Q_MIN));
		table_rows.push_back(req_row(MODE_EVAL, Q_MAX, 0, 0, 0));
		table_rows.push_back(req_row(MODE_EVAL, Q_MIN, 0, 0, 0));
		table_rows.push_back(req_row(MODE_MIN, Q_MAX, 0, 0, 0));

		foreach (table_rows[i]) begin
			r = table_rows[i];
			if (r.kind == ROW_CFG) begin
				start <= 1'b0;
				write_reg(r.idx, r.data);
			end else begin
				issue_request(r.md, r.qx, r.typed, r.exp);
			end
		end

		for (int ph = 0; ph < 12; ph++) begin
			start <= 1'b0;
			random_setting();
			case (ph % 3)
				0: idle_pct = 0;
				1: idle_pct = 55;
				default: idle_pct = 6;
			endcase
			lo = end_regs[chlsi_pkg::REG_LEFT_X] < end_regs[chlsi_pkg::REG_RIGHT_X] ?
				end_regs[chlsi_pkg::REG_LEFT_X] : end_regs[chlsi_pkg::REG_RIGHT_X];
			span = end_regs[chlsi_pkg::REG_RIGHT_X] - end_regs[chlsi_pkg::REG_LEFT_X];
			if (span < 0) span = -span;
			if (span > 32'sh100000 || span == 0) span = 32'sh100000;
			for (int n = 0; n < 67; n++) begin
				if ($urandom_range(9) < 7)
					q = lo - span / 2 + $signed($urandom_range(2 * span));
				else
					q = $urandom;
				issue_request(1'($urandom_range(1)), q, 0, interp_t'('0));
			end
		end

		start <= 1'b0;
		wait_drained();
		if (errors == 0)
			$display("cubic_hermite_line_search_interpolant_test: clean");
		else
			$display("cubic_hermite_line_search_interpolant_test: errors");
		$finish;
	end

endmodule

// File: sim.f
rtl/chlsi_pkg.sv
rtl/chlsi_div.sv
rtl/chlsi_sqrt.sv
rtl/chlsi_setup.sv
rtl/chlsi_eval.sv
rtl/cubic_hermite_line_search_interpolant.sv
tb/cubic_hermite_line_search_interpolant_test.sv
